FILE: hw/rtl/calendar_date_arithmetic_core_macros.svh
// ----------------------------------------------------------------------------
// Calendar date arithmetic assertion macros
// Concurrent assertion helpers, empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ARITHMETIC_CORE_MACROS_SVH
`define CALENDAR_DATE_ARITHMETIC_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CAD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
`define CAD_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");
`else
`define CAD_ASSERT(lbl, clk, rst_n, prop)
`define CAD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hw/rtl/cad_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date arithmetic package
// Shared types, selector codes and month length helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cad_pkg;

	localparam int MAX_DAY_STEPS_DEF = 32768;
	localparam logic [13:0] YEAR_MAX = 14'd9999;
	localparam logic [16:0] MONTH_IDX_MAX = 17'd119999;

	localparam logic [2:0] FN_CHECK   = 3'd0;
	localparam logic [2:0] FN_NEXT    = 3'd1;
	localparam logic [2:0] FN_PREV    = 3'd2;
	localparam logic [2:0] FN_DAYS    = 3'd3;
	localparam logic [2:0] FN_MONTHS  = 3'd4;
	localparam logic [2:0] FN_COMPARE = 3'd5;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
	} date_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_STEP,
		ST_MDIV,
		ST_MFIX,
		ST_PACK
	} cad_state_t;

	function automatic logic [4:0] days_in(input logic [3:0] m, input logic [13:0] y);
		logic [4:0] n;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			4'd2: n = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
			default: n = 5'd0;
		endcase
		return n;
	endfunction

	function automatic logic date_valid(input logic [5:0] d, input logic [3:0] m,
			input logic [13:0] y);
		return (y <= YEAR_MAX) && (m >= 4'd1) && (m <= 4'd12) && (d >= 6'd1) &&
			(d <= {1'b0, days_in(m, y)});
	endfunction

endpackage

FILE: hw/rtl/cad_step.sv
// ----------------------------------------------------------------------------
// Calendar day stepper
// Moves a valid date one day forward or back and flags year range exits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cad_step import cad_pkg::*; (
	input  date_t cur,
	input  logic  dir,
	output date_t nxt,
	output logic  ok
);

	logic [4:0] len_cur;
	logic [4:0] len_prev;

	assign len_cur = days_in(cur.month, cur.year);
	assign len_prev = days_in(cur.month - 4'd1, cur.year);

	always_comb begin
		nxt = cur;
		ok = 1'b1;
		if (!dir) begin
			if (cur.day < len_cur) begin
				nxt.day = cur.day + 5'd1;
			end else if (cur.month < 4'd12) begin
				nxt.day = 5'd1;
				nxt.month = cur.month + 4'd1;
			end else if (cur.year >= YEAR_MAX) begin
				ok = 1'b0;
			end else begin
				nxt.day = 5'd1;
				nxt.month = 4'd1;
				nxt.year = cur.year + 14'd1;
			end
		end else begin
			if (cur.day > 5'd1) begin
				nxt.day = cur.day - 5'd1;
			end else if (cur.month > 4'd1) begin
				nxt.month = cur.month - 4'd1;
				nxt.day = len_prev;
			end else if (cur.year == 14'd0) begin
				ok = 1'b0;
			end else begin
				nxt.day = 5'd31;
				nxt.month = 4'd12;
				nxt.year = cur.year - 14'd1;
			end
		end
	end

endmodule

FILE: hw/rtl/calendar_date_arithmetic_core.sv
// ----------------------------------------------------------------------------
// Calendar date arithmetic core
// Checks, steps, shifts and compares day/month/year dates under a sequencer.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until the result beat, which appears for one cycle with done high and must
// be captured then. Check and compare go from the check state to pack, day
// steps run through the step state and add months through divide and fix.
// Add days moves the date n days, n being the magnitude of amount saturated
// at MAX_DAY_STEPS; the single day stepper advances the date one day per cycle.
`timescale 1ns / 1ps
`include "calendar_date_arithmetic_core_macros.svh"

module calendar_date_arithmetic_core import cad_pkg::*; #(
	parameter int MAX_DAY_STEPS = MAX_DAY_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         func,
	input  logic [5:0]         day_a,
	input  logic [3:0]         month_a,
	input  logic [13:0]        year_a,
	input  logic [5:0]         day_b,
	input  logic [3:0]         month_b,
	input  logic [13:0]        year_b,
	input  logic signed [15:0] amount,
	output logic               done,
	output logic [4:0]         day_out,
	output logic [3:0]         month_out,
	output logic [13:0]        year_out,
	output logic               result_valid,
	output logic               is_less,
	output logic               is_equal,
	output logic               is_greater,
	output logic signed [27:0] packed_date
);

	localparam int CNT_W = $clog2(MAX_DAY_STEPS + 1);

	cad_state_t state_q, state_d;

	logic [2:0]         func_q;
	logic [5:0]         da_q, db_q;
	logic [3:0]         ma_q, mb_q;
	logic [13:0]        ya_q, yb_q;
	logic signed [15:0] amt_q;
	date_t              cur_q;
	logic               ok_q, dir_q, lt_q, eq_q, gt_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [16:0]        t_q;
	logic [13:0]        q_q;
	logic               done_q;

	logic               a_ok, b_ok, fn_ok, t_bad;
	logic [16:0]        mag;
	logic [CNT_W-1:0]   n_steps;
	logic [17:0]        t_base;
	logic signed [18:0] t_full;
	logic [31:0]        q_prod;
	logic [16:0]        rem;
	logic [3:0]         m_new;
	logic [4:0]         len_new;
	date_t              step_nxt;
	logic               step_ok;

	cad_step u_step (
		.cur (cur_q),
		.dir (dir_q),
		.nxt (step_nxt),
		.ok  (step_ok)
	);

	assign a_ok = date_valid(da_q, ma_q, ya_q);
	assign b_ok = date_valid(db_q, mb_q, yb_q);
	assign fn_ok = (func_q <= FN_COMPARE) && (func_q != FN_COMPARE || b_ok);
	assign mag = amt_q[15] ? (17'd0 - {amt_q[15], amt_q}) : {1'b0, amt_q};
	assign n_steps = (32'(mag) > 32'(MAX_DAY_STEPS)) ? CNT_W'(MAX_DAY_STEPS) : CNT_W'(mag);
	assign t_base = 18'(ya_q) * 18'd12 + 18'(ma_q) - 18'd1;
	assign t_full = $signed({1'b0, t_base}) + $signed({{3{amt_q[15]}}, amt_q});
	assign t_bad = t_full[18] || (t_full[17:0] > {1'b0, MONTH_IDX_MAX});
	assign q_prod = 32'(t_q[16:2]) * 32'd43691;
	assign rem = t_q - 17'(q_q) * 17'd12;
	assign m_new = rem[3:0] + 4'd1;
	assign len_new = days_in(m_new, q_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!a_ok || !fn_ok) begin
					state_d = ST_PACK;
				end else if (func_q == FN_NEXT || func_q == FN_PREV || func_q == FN_DAYS) begin
					state_d = ST_STEP;
				end else if (func_q == FN_MONTHS && !t_bad) begin
					state_d = ST_MDIV;
				end else begin
					state_d = ST_PACK;
				end
			end
			ST_STEP: begin
				if (cnt_q == '0 || !step_ok) begin
					state_d = ST_PACK;
				end
			end
			ST_MDIV: state_d = ST_MFIX;
			ST_MFIX: state_d = ST_PACK;
			ST_PACK: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_PACK);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				func_q <= func;
				da_q <= day_a;
				ma_q <= month_a;
				ya_q <= year_a;
				db_q <= day_b;
				mb_q <= month_b;
				yb_q <= year_b;
				amt_q <= amount;
			end
			ST_CHECK: begin
				cur_q <= '{day: da_q[4:0], month: ma_q, year: ya_q};
				ok_q <= a_ok && fn_ok && (func_q != FN_MONTHS || !t_bad);
				lt_q <= (func_q == FN_COMPARE) && a_ok && b_ok &&
					({ya_q, ma_q, da_q} < {yb_q, mb_q, db_q});
				eq_q <= (func_q == FN_COMPARE) && a_ok && b_ok &&
					({ya_q, ma_q, da_q} == {yb_q, mb_q, db_q});
				gt_q <= (func_q == FN_COMPARE) && a_ok && b_ok &&
					({ya_q, ma_q, da_q} > {yb_q, mb_q, db_q});
				dir_q <= (func_q == FN_PREV) || (func_q == FN_DAYS && amt_q[15]);
				if (func_q == FN_NEXT || func_q == FN_PREV) begin
					cnt_q <= CNT_W'(1);
				end else if (func_q == FN_DAYS) begin
					cnt_q <= n_steps;
				end else begin
					cnt_q <= '0;
				end
				t_q <= t_full[16:0];
			end
			ST_STEP: begin
				if (cnt_q != '0) begin
					if (!step_ok) begin
						ok_q <= 1'b0;
					end else begin
						cur_q <= step_nxt;
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
			end
			ST_MDIV: begin
				q_q <= q_prod[30:17];
			end
			ST_MFIX: begin
				cur_q.year <= q_q;
				cur_q.month <= m_new;
				if (cur_q.day > len_new) begin
					cur_q.day <= len_new;
				end
			end
			ST_PACK: begin
				if (ok_q) begin
					day_out <= cur_q.day;
					month_out <= cur_q.month;
					year_out <= cur_q.year;
					packed_date <= $signed(28'(cur_q.year) * 28'd10000 +
						28'(cur_q.month) * 28'd100 + 28'(cur_q.day));
				end else begin
					day_out <= '0;
					month_out <= '0;
					year_out <= '0;
					packed_date <= '1;
				end
				result_valid <= ok_q;
				is_less <= lt_q;
				is_equal <= eq_q;
				is_greater <= gt_q;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;

	`CAD_ASSERT(a_done_single, clk, arst_n, done |=> !done)
	`CAD_ASSERT(a_start_busy, clk, arst_n, (start && !busy) |=> busy)
	`CAD_ASSERT(a_cmp_onehot, clk, arst_n, done |-> $onehot0({is_less, is_equal, is_greater}))
	`CAD_ASSERT(a_invalid_zero, clk, arst_n,
		(done && !result_valid) |-> (packed_date == -28'sd1 && month_out == 4'd0))
	`CAD_ASSERT(a_step_count, clk, arst_n,
		(state_q == ST_STEP && cnt_q != '0 && step_ok) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
	`CAD_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> !done)

endmodule
